[hw/rtl/tun_pkg.sv]
// Shared types and constants for the triangle unit normal block.
`timescale 1ns / 1ps
`default_nettype none
package tun_pkg;

   localparam int COORD_WIDTH = 24;
   localparam int NORMAL_WIDTH = 16;
   localparam int FRAC_BITS = NORMAL_WIDTH - 1;
   localparam int DIFF_W = COORD_WIDTH + 1;
   localparam int PRE_W = $clog2(DIFF_W + 1);
   localparam int SCL_W = (DIFF_W > 31) ? 31 : DIFF_W;
   localparam int PROD_W = 2 * SCL_W;
   localparam int CROSS_W = PROD_W + 1;
   localparam int MSB_W = $clog2(CROSS_W);
   localparam int NORM_W = 31;
   localparam int NORM_TOP = NORM_W - 1;
   localparam int SUM_W = 64;
   localparam int ROOT_W = 32;
   localparam int QUO_W = NORMAL_WIDTH;
   localparam int DIV_W = NORM_W + QUO_W + 2;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] first_x;
      logic signed [COORD_WIDTH-1:0] first_y;
      logic signed [COORD_WIDTH-1:0] first_z;
      logic signed [COORD_WIDTH-1:0] second_x;
      logic signed [COORD_WIDTH-1:0] second_y;
      logic signed [COORD_WIDTH-1:0] second_z;
      logic signed [COORD_WIDTH-1:0] third_x;
      logic signed [COORD_WIDTH-1:0] third_y;
      logic signed [COORD_WIDTH-1:0] third_z;
   } req_type;

   typedef struct packed {
      logic signed [NORMAL_WIDTH-1:0] normal_x;
      logic signed [NORMAL_WIDTH-1:0] normal_y;
      logic signed [NORMAL_WIDTH-1:0] normal_z;
      logic                           degenerate;
   } rsp_type;

   typedef struct packed {
      logic signed [CROSS_W-1:0] c0;
      logic signed [CROSS_W-1:0] c1;
      logic signed [CROSS_W-1:0] c2;
   } cross_type;

   typedef struct packed {
      logic [2:0][NORM_W-1:0] a;
      logic [2:0]             neg;
      logic                   degen;
   } norm_type;

endpackage
`default_nettype wire

[hw/rtl/tun_front.sv]
// Front pipeline: edge differences, wide prescale and cross product.
`timescale 1ns / 1ps
`default_nettype none
module tun_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire tun_pkg::req_type   in_data,
   output logic                    out_valid,
   output tun_pkg::cross_type      out_data
);
   import tun_pkg::*;

   logic [3:0] v_ff;
   logic signed [DIFF_W-1:0] d_ff [6];
   logic signed [DIFF_W-1:0] d_in [6];
   logic signed [SCL_W-1:0]  s_ff [6];
   logic signed [SCL_W-1:0]  s_in [6];
   logic signed [PROD_W-1:0] p_ff [6];
   logic signed [PROD_W-1:0] p_in [6];
   cross_type                c_ff;
   cross_type                c_in;
   logic [DIFF_W-1:0]        mag [6];
   logic [DIFF_W-1:0]        smag [6];
   logic [DIFF_W-1:0]        orv;
   logic [PRE_W-1:0]         sh;

   always_comb begin
      d_in[0] = DIFF_W'(in_data.second_x) - DIFF_W'(in_data.first_x);
      d_in[1] = DIFF_W'(in_data.second_y) - DIFF_W'(in_data.first_y);
      d_in[2] = DIFF_W'(in_data.second_z) - DIFF_W'(in_data.first_z);
      d_in[3] = DIFF_W'(in_data.third_x) - DIFF_W'(in_data.second_x);
      d_in[4] = DIFF_W'(in_data.third_y) - DIFF_W'(in_data.second_y);
      d_in[5] = DIFF_W'(in_data.third_z) - DIFF_W'(in_data.second_z);
   end

   always_comb begin
      orv = '0;
      for (int i = 0; i < 6; i++) begin
         mag[i] = d_ff[i][DIFF_W-1] ? DIFF_W'(-d_ff[i]) : DIFF_W'(d_ff[i]);
         orv = orv | mag[i];
      end
      sh = '0;
      for (int i = 30; i < DIFF_W; i++) begin
         if (orv[i]) sh = PRE_W'(i - 29);
      end
      for (int i = 0; i < 6; i++) begin
         smag[i] = mag[i] >> sh;
         s_in[i] = d_ff[i][DIFF_W-1] ? -$signed(SCL_W'(smag[i])) : $signed(SCL_W'(smag[i]));
      end
   end

   always_comb begin
      p_in[0] = s_ff[1] * s_ff[5];
      p_in[1] = s_ff[2] * s_ff[4];
      p_in[2] = s_ff[2] * s_ff[3];
      p_in[3] = s_ff[0] * s_ff[5];
      p_in[4] = s_ff[0] * s_ff[4];
      p_in[5] = s_ff[1] * s_ff[3];
      c_in.c0 = CROSS_W'(p_ff[0]) - CROSS_W'(p_ff[1]);
      c_in.c1 = CROSS_W'(p_ff[2]) - CROSS_W'(p_ff[3]);
      c_in.c2 = CROSS_W'(p_ff[4]) - CROSS_W'(p_ff[5]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      d_ff <= d_in;
      s_ff <= s_in;
      p_ff <= p_in;
      c_ff <= c_in;
   end

   assign out_valid = v_ff[3];
   assign out_data = c_ff;

endmodule
`default_nettype wire

[hw/rtl/tun_queue.sv]
// Short queue of cross products between the front and back pipelines.
`timescale 1ns / 1ps
`default_nettype none
module tun_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire tun_pkg::cross_type  push_data,
   input  wire logic                pop,
   output tun_pkg::cross_type       head,
   output logic                     empty,
   output logic                     full
);
   import tun_pkg::*;

   cross_type mem [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QUEUE_AW:0]   cnt_ff, cnt_in;
   logic                do_pop;

   assign empty = (cnt_ff == '0);
   assign full = (cnt_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign do_pop = pop && !empty;
   assign head = mem[rd_ff];

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      if (push) wr_in = (wr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (do_pop) rd_in = (rd_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      cnt_in = cnt_ff + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem[wr_ff] <= push_data;
   end

endmodule
`default_nettype wire

[hw/rtl/tun_back.sv]
// Back pipeline: normalize, square root of the sum of squares, divide and round.
`timescale 1ns / 1ps
`default_nettype none
module tun_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire tun_pkg::cross_type in_data,
   output logic                    out_valid,
   output tun_pkg::rsp_type        out_data
);
   import tun_pkg::*;

   logic [3:0]               v_ff;
   logic [2:0][CROSS_W-1:0]  m_ff, m_in;
   logic [2:0]               neg_ff, neg_in;
   logic                     dg_ff, dg_in;
   logic [MSB_W-1:0]         msb_ff, msb_in;
   logic [CROSS_W-1:0]       orv;
   norm_type                 n_ff, n_in, n2_ff, n3_ff;
   logic [2*NORM_W-1:0]      sq_ff [3];
   logic [SUM_W-1:0]         sum_ff;

   always_comb begin
      m_in[0] = in_data.c0[CROSS_W-1] ? CROSS_W'(-in_data.c0) : CROSS_W'(in_data.c0);
      m_in[1] = in_data.c1[CROSS_W-1] ? CROSS_W'(-in_data.c1) : CROSS_W'(in_data.c1);
      m_in[2] = in_data.c2[CROSS_W-1] ? CROSS_W'(-in_data.c2) : CROSS_W'(in_data.c2);
      neg_in = {in_data.c2[CROSS_W-1], in_data.c1[CROSS_W-1], in_data.c0[CROSS_W-1]};
      orv = m_in[0] | m_in[1] | m_in[2];
      dg_in = (orv == '0);
      msb_in = '0;
      for (int i = 0; i < CROSS_W; i++) begin
         if (orv[i]) msb_in = MSB_W'(i);
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (msb_ff >= MSB_W'(NORM_TOP)) begin
            n_in.a[i] = NORM_W'(m_ff[i] >> (msb_ff - MSB_W'(NORM_TOP)));
         end else begin
            n_in.a[i] = NORM_W'(m_ff[i] << (MSB_W'(NORM_TOP) - msb_ff));
         end
      end
      n_in.neg = neg_ff;
      n_in.degen = dg_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      m_ff <= m_in;
      neg_ff <= neg_in;
      dg_ff <= dg_in;
      msb_ff <= msb_in;
      n_ff <= n_in;
      for (int i = 0; i < 3; i++) sq_ff[i] <= n_ff.a[i] * n_ff.a[i];
      n2_ff <= n_ff;
      sum_ff <= SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);
      n3_ff <= n2_ff;
   end

   logic                  sr_v    [ROOT_W+1];
   logic [SUM_W-1:0]      sr_rem  [ROOT_W+1];
   logic [ROOT_W-1:0]     sr_root [ROOT_W+1];
   norm_type              sr_n    [ROOT_W+1];

   assign sr_v[0] = v_ff[3];
   assign sr_rem[0] = sum_ff;
   assign sr_root[0] = '0;
   assign sr_n[0] = n3_ff;

   for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
      localparam int B = ROOT_W - 1 - k;
      logic [SUM_W+1:0] trial;
      logic             take;
      assign trial = ((SUM_W+2)'(sr_root[k]) << (B + 1)) + ((SUM_W+2)'(1) << (2 * B));
      assign take = ((SUM_W+2)'(sr_rem[k]) >= trial);
      always_ff @(posedge clock) begin
         if (reset) begin
            sr_v[k+1] <= 1'b0;
         end else begin
            sr_v[k+1] <= sr_v[k];
         end
      end
      always_ff @(posedge clock) begin
         sr_rem[k+1] <= take ? SUM_W'((SUM_W+2)'(sr_rem[k]) - trial) : sr_rem[k];
         sr_root[k+1] <= take ? (sr_root[k] | (ROOT_W'(1) << B)) : sr_root[k];
         sr_n[k+1] <= sr_n[k];
      end
   end

   logic                        dv_v   [QUO_W+1];
   logic [2:0][DIV_W-1:0]       dv_rem [QUO_W+1];
   logic [2:0][QUO_W-1:0]       dv_q   [QUO_W+1];
   logic [DIV_W-1:0]            dv_den [QUO_W+1];
   logic [2:0]                  dv_neg [QUO_W+1];
   logic                        dv_dg  [QUO_W+1];

   assign dv_v[0] = sr_v[ROOT_W];
   assign dv_den[0] = DIV_W'(sr_root[ROOT_W]) << 1;
   assign dv_neg[0] = sr_n[ROOT_W].neg;
   assign dv_dg[0] = sr_n[ROOT_W].degen;
   assign dv_q[0] = '0;
   for (genvar i = 0; i < 3; i++) begin : g_num
      assign dv_rem[0][i] = (DIV_W'(sr_n[ROOT_W].a[i]) << (FRAC_BITS + 1))
                            + DIV_W'(sr_root[ROOT_W]);
   end

   for (genvar j = 0; j < QUO_W; j++) begin : g_div
      localparam int K = QUO_W - 1 - j;
      logic [DIV_W-1:0] cmp;
      assign cmp = dv_den[j] << K;
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v[j+1] <= 1'b0;
         end else begin
            dv_v[j+1] <= dv_v[j];
         end
      end
      always_ff @(posedge clock) begin
         for (int i = 0; i < 3; i++) begin
            if (dv_rem[j][i] >= cmp) begin
               dv_rem[j+1][i] <= dv_rem[j][i] - cmp;
               dv_q[j+1][i] <= dv_q[j][i] | (QUO_W'(1) << K);
            end else begin
               dv_rem[j+1][i] <= dv_rem[j][i];
               dv_q[j+1][i] <= dv_q[j][i];
            end
         end
         dv_den[j+1] <= dv_den[j];
         dv_neg[j+1] <= dv_neg[j];
         dv_dg[j+1] <= dv_dg[j];
      end
   end

   logic                      o_v_ff;
   rsp_type                   o_ff, o_in;
   logic [2:0][QUO_W-1:0]     qs;
   localparam logic [QUO_W-1:0] MAX_POS = (QUO_W'(1) << FRAC_BITS) - QUO_W'(1);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         qs[i] = dv_q[QUO_W][i];
         if (!dv_neg[QUO_W][i] && qs[i] > MAX_POS) qs[i] = MAX_POS;
         if (dv_neg[QUO_W][i]) qs[i] = -qs[i];
         if (dv_dg[QUO_W]) qs[i] = '0;
      end
      o_in.normal_x = $signed(NORMAL_WIDTH'(qs[0]));
      o_in.normal_y = $signed(NORMAL_WIDTH'(qs[1]));
      o_in.normal_z = $signed(NORMAL_WIDTH'(qs[2]));
      o_in.degenerate = dv_dg[QUO_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_v_ff <= 1'b0;
      end else begin
         o_v_ff <= dv_v[QUO_W];
      end
   end

   always_ff @(posedge clock) begin
      o_ff <= o_in;
   end

   assign out_valid = o_v_ff;
   assign out_data = o_ff;

endmodule
`default_nettype wire

[hw/rtl/triangle_unit_normal.sv]
// Top level of the triangle unit normal block.
// Throughput: one request per cycle; the 32-stage square root and the 16-stage
// divider are fully pipelined, so busy stays low in operation.
// Reset: synchronous and active high; it clears all valid flags and the queue.
// The receiver cannot stall; each result shows for one cycle with rsp_valid.
`timescale 1ns / 1ps
`default_nettype none
module triangle_unit_normal (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire tun_pkg::req_type  req_data,
   output logic                   rsp_valid,
   output tun_pkg::rsp_type       rsp_data
);
   import tun_pkg::*;

   logic      f_valid;
   cross_type f_data;
   cross_type q_head;
   logic      q_empty;
   logic      q_full;

   tun_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_data   (req_data),
      .out_valid (f_valid),
      .out_data  (f_data)
   );

   tun_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_valid),
      .push_data (f_data),
      .pop       (1'b1),
      .head      (q_head),
      .empty     (q_empty),
      .full      (q_full)
   );

   tun_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (!q_empty),
      .in_data   (q_head),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

   assign busy = q_full;

endmodule
`default_nettype wire

[hw/rtl/tun_checker.sv]
// Port-level assertions for the triangle unit normal block and their binding.
`timescale 1ns / 1ps
`default_nettype none
module tun_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             busy,
   input wire logic             rsp_valid,
   input wire tun_pkg::rsp_type rsp_data
);
   import tun_pkg::*;

   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result right after reset");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.degenerate) |->
      (rsp_data.normal_x == '0 && rsp_data.normal_y == '0 && rsp_data.normal_z == '0))
      else $error("degenerate result with nonzero normal");

   a_normal_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.degenerate) |->
      (rsp_data.normal_x != '0 || rsp_data.normal_y != '0 || rsp_data.normal_z != '0))
      else $error("zero normal without degenerate flag");

endmodule

bind triangle_unit_normal tun_checker u_tun_checker (.*);
`default_nettype wire

[sim/testbench.sv]
// Self-checking testbench for the triangle unit normal block.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
   import tun_pkg::*;

   localparam int LATENCY = 58;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_COUNT = 1530;
   localparam int CALM_COUNT = 300;

   typedef struct {
      req_type tri_in;
      logic    has_expect;
      rsp_type want;
   } stim_row_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   rsp_type     normal_queue[$];
   int          error_count;
   int          idle_cycles;
   logic        accepted;
   stim_row_type rows[$];

   triangle_unit_normal i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [63:0] magnitude(input logic signed [63:0] v);
      return v < 0 ? -v : v;
   endfunction

   function automatic logic [63:0] int_sqrt(input logic [63:0] x);
      logic [63:0] root;
      logic [63:0] bit_val;
      root = 0;
      bit_val = 64'd1 << 62;
      while (bit_val > x) bit_val = bit_val >> 2;
      while (bit_val != 0) begin
         if (x >= root + bit_val) begin
            x = x - (root + bit_val);
            root = (root >> 1) + bit_val;
         end else begin
            root = root >> 1;
         end
         bit_val = bit_val >> 2;
      end
      return root;
   endfunction

   function automatic rsp_type face_normal(input req_type t);
      logic signed [63:0] p[9];
      logic signed [63:0] d[6];
      logic signed [63:0] c[3];
      logic [63:0] a[3];
      logic [63:0] peak;
      logic [63:0] sum;
      logic [63:0] len;
      logic [63:0] q;
      logic [63:0] full;
      logic signed [63:0] v;
      rsp_type r;
      p[0] = 64'(t.first_x);  p[1] = 64'(t.first_y);  p[2] = 64'(t.first_z);
      p[3] = 64'(t.second_x); p[4] = 64'(t.second_y); p[5] = 64'(t.second_z);
      p[6] = 64'(t.third_x);  p[7] = 64'(t.third_y);  p[8] = 64'(t.third_z);
      for (int i = 0; i < 3; i++) begin
         d[i] = p[3+i] - p[i];
         d[3+i] = p[6+i] - p[3+i];
      end
      c[0] = d[1] * d[5] - d[2] * d[4];
      c[1] = d[2] * d[3] - d[0] * d[5];
      c[2] = d[0] * d[4] - d[1] * d[3];
      peak = 0;
      for (int i = 0; i < 3; i++) begin
         a[i] = magnitude(c[i]);
         if (a[i] > peak) peak = a[i];
      end
      r = '0;
      if (peak == 0) begin
         r.degenerate = 1'b1;
         return r;
      end
      while (peak >= (64'd1 << 31)) begin
         peak = peak >> 1;
         for (int i = 0; i < 3; i++) a[i] = a[i] >> 1;
      end
      while (peak < (64'd1 << 30)) begin
         peak = peak << 1;
         for (int i = 0; i < 3; i++) a[i] = a[i] << 1;
      end
      sum = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
      len = int_sqrt(sum);
      full = 64'd1 << FRAC_BITS;
      for (int i = 0; i < 3; i++) begin
         q = (a[i] * full * 2 + len) / (2 * len);
         if (c[i] < 0) begin
            if (q > full) q = full;
            v = -$signed(q);
         end else begin
            if (q > full - 1) q = full - 1;
            v = $signed(q);
         end
         case (i)
            0: r.normal_x = v[NORMAL_WIDTH-1:0];
            1: r.normal_y = v[NORMAL_WIDTH-1:0];
            default: r.normal_z = v[NORMAL_WIDTH-1:0];
         endcase
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch in %s: got %0d, expected %0d", what, got, want);
      error_count++;
   endtask

   function automatic req_type make_tri(input int ax, ay, az, bx, by, bz, cx, cy, cz);
      req_type t;
      t.first_x = 24'(ax);  t.first_y = 24'(ay);  t.first_z = 24'(az);
      t.second_x = 24'(bx); t.second_y = 24'(by); t.second_z = 24'(bz);
      t.third_x = 24'(cx);  t.third_y = 24'(cy);  t.third_z = 24'(cz);
      return t;
   endfunction

   function automatic rsp_type make_normal(input int nx, ny, nz, input logic degen);
      rsp_type r;
      r.normal_x = 16'(nx);
      r.normal_y = 16'(ny);
      r.normal_z = 16'(nz);
      r.degenerate = degen;
      return r;
   endfunction

   task automatic add_row(input req_type t, input logic has_expect, input rsp_type want);
      stim_row_type row;
      row.tri_in = t;
      row.has_expect = has_expect;
      row.want = want;
      rows.insert(rows.size(), row);
   endtask

   function automatic logic signed [23:0] random_coord();
      case ($urandom_range(0, 5))
         0: return 24'sh7fffff;
         1: return 24'sh800000;
         2: return $signed(24'($urandom_range(0, 63)) - 24'd32);
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic req_type random_tri();
      req_type t;
      logic signed [23:0] base;
      int spread;
      if ($urandom_range(0, 9) == 0) begin
         base = random_coord();
         t = '{default: base};
         if ($urandom_range(0, 1)) t.third_x = random_coord();
      end else if ($urandom_range(0, 2) == 0) begin
         spread = $urandom_range(1, 4096);
         base = 24'($urandom);
         t.first_x = base; t.first_y = 24'($urandom); t.first_z = 24'($urandom);
         t.second_x = t.first_x + 24'($urandom_range(0, spread));
         t.second_y = t.first_y + 24'($urandom_range(0, spread));
         t.second_z = t.first_z - 24'($urandom_range(0, spread));
         t.third_x = t.second_x - 24'($urandom_range(0, spread));
         t.third_y = t.second_y + 24'($urandom_range(0, spread));
         t.third_z = t.second_z + 24'($urandom_range(0, spread));
      end else begin
         t = {random_coord(), random_coord(), random_coord(),
              random_coord(), random_coord(), random_coord(),
              random_coord(), random_coord(), random_coord()};
      end
      return t;
   endfunction

   task automatic send_request(input req_type t, input logic has_expect, input rsp_type want,
                               input logic allow_gaps);
      rsp_type predicted;
      if (allow_gaps && $urandom_range(0, 7) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      predicted = face_normal(t);
      if (has_expect && predicted !== want)
         report_mismatch("directed prediction", 0, 1);
      req_data <= t;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      normal_queue.insert(normal_queue.size(), has_expect ? want : predicted);
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      accepted = 1'b0;
      if (!reset) begin
         if (start && !busy) accepted = 1'b1;
         if (rsp_valid) begin
            accepted = 1'b1;
            if (normal_queue.size() == 0) begin
               report_mismatch("unexpected result", 1, 0);
            end else begin
               automatic rsp_type want = normal_queue.pop_front();
               if (rsp_data.normal_x !== want.normal_x)
                  report_mismatch("normal_x", int'(rsp_data.normal_x), int'(want.normal_x));
               if (rsp_data.normal_y !== want.normal_y)
                  report_mismatch("normal_y", int'(rsp_data.normal_y), int'(want.normal_y));
               if (rsp_data.normal_z !== want.normal_z)
                  report_mismatch("normal_z", int'(rsp_data.normal_z), int'(want.normal_z));
               if (rsp_data.degenerate !== want.degenerate)
                  report_mismatch("degenerate", int'(rsp_data.degenerate),
                                  int'(want.degenerate));
            end
         end
      end
      idle_cycles = accepted ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   initial begin
      rsp_type none;
      none = '0;
      error_count = 0;
      idle_cycles = 0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      add_row(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, make_normal(0, 0, 0, 1'b1));
      add_row(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0), 1'b1, make_normal(0, 0, 32767, 1'b0));
      add_row(make_tri(0, 0, 0, 0, 1, 0, 1, 0, 0), 1'b1, make_normal(0, 0, -32768, 1'b0));
      add_row(make_tri(0, 0, 0, 0, 1, 0, 0, 0, 1), 1'b1, make_normal(32767, 0, 0, 1'b0));
      add_row(make_tri(0, 0, 0, 0, 0, 1, 0, 1, 0), 1'b1, make_normal(-32768, 0, 0, 1'b0));
      add_row(make_tri(0, 0, 0, 0, 0, 1, 1, 0, 0), 1'b1, make_normal(0, 32767, 0, 1'b0));
      add_row(make_tri(0, 0, 0, 1, 1, 1, 2, 2, 2), 1'b1, make_normal(0, 0, 0, 1'b1));
      add_row(make_tri(-8388608, -8388608, -8388608, 8388607, -8388608, -8388608,
                       8388607, 8388607, -8388608), 1'b1, make_normal(0, 0, 32767, 1'b0));
      add_row(make_tri(8388607, 8388607, 8388607, -8388608, -8388608, -8388608,
                       8388607, 8388607, 8388607), 1'b1, make_normal(0, 0, 0, 1'b1));
      add_row(make_tri(8388607, 0, 0, 0, 8388607, 0, 0, 0, 8388607), 1'b0, none);
      add_row(make_tri(-8388608, 0, 0, 0, -8388608, 0, 0, 0, -8388608), 1'b0, none);
      add_row(make_tri(-8388608, 8388607, -8388608, 8388607, -8388608, 8388607,
                       -8388608, -8388608, 8388607), 1'b0, none);
      add_row(make_tri(1, 2, 3, 4, 6, 8, -5, 7, -9), 1'b0, none);
      add_row(make_tri(0, 0, 0, 1, 0, 0, 8388607, 1, 0), 1'b0, none);
      add_row(make_tri(-1, -1, -1, 1, 1, 1, 1, 1, -1), 1'b0, none);
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (rows[k]) send_request(rows[k].tri_in, rows[k].has_expect, rows[k].want, 1'b1);
      start <= 1'b0;
      while (normal_queue.size() != 0) @(posedge clock);
      @(negedge clock);
      for (int k = 0; k < RANDOM_COUNT; k++) begin
         if (k == RANDOM_COUNT / 2) begin
            start <= 1'b0;
            while (normal_queue.size() != 0) @(posedge clock);
            @(negedge clock);
         end
         send_request(random_tri(), 1'b0, none, k < RANDOM_COUNT - CALM_COUNT);
      end
      start <= 1'b0;
      while (normal_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
`default_nettype wire
